// ===== sv/pad_input_run_length_recorder_macros.svh =====
// Assertion macros for the pad input run-length recorder
`ifndef PAD_INPUT_RUN_LENGTH_RECORDER_MACROS_SVH
`define PAD_INPUT_RUN_LENGTH_RECORDER_MACROS_SVH

`ifndef SYNTH
`define PRLR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PRLR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PRLR_ASSERT_IMP(lbl, ante, cons)
`define PRLR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== sv/prlr_pkg.sv =====
// Shared types and constants of the pad input run-length recorder
package prlr_pkg;

    localparam int NUM_CH      = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int ADDR_W      = 3;

    localparam logic REG_CAMERA_MODE = 1'b0;
    localparam logic REG_LINK_MASK   = 1'b1;
    localparam logic [31:0] LINK_MASK_RESET = 32'h0000_0008;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_STOP   = 2'd2;

    localparam logic [2:0] CH_BUTTONS = 3'd0;
    localparam logic [2:0] CH_LAST    = 3'd4;

    typedef enum logic [2:0] {
        ST_RUN     = 3'd0,
        ST_CHUNK   = 3'd1,
        ST_DISCONN = 3'd2,
        ST_ORDER   = 3'd3,
        ST_REFUSED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_START  = 3'd0,
        OP_STOP   = 3'd1,
        OP_REFUSE = 3'd2,
        OP_DISC   = 3'd3,
        OP_ORDER  = 3'd4,
        OP_SAMPLE = 3'd5
    } op_t;

    // a: step (sample) or quarter frame (order); b: frame after the request
    typedef struct packed {
        op_t                      op;
        logic [NUM_CH-1:0][31:0]  vals;
        logic                     pressed_nz;
        logic                     link;
        logic                     missed;
        logic [31:0]              a;
        logic [31:0]              b;
    } cmd_t;

endpackage

// ===== sv/pad_input_run_length_recorder.sv =====
// Top level of the pad input run-length recorder
//
// Requests enter on req_valid/req_ready with kind and the pad sample fields; results
// leave on res_valid/res_ready, one record per accepted handshake, with last set on
// the final record a request causes. Registers camera_mode (0x0) and link_button_mask
// (0x4) are APB registers; users must write them while idle; the block does not check.
// The front accepts one request per cycle into a two-entry queue while the queue
// has room. The back walks the five channels serially, one channel per cycle unless
// a record waits for the result register, and fills it at most once per cycle:
//   start, stop: no record from the back; ignored and dropped requests never reach
//   the queue;
//   status-only records: written straight from idle;
//   samples: one scan step per channel, plus with a link press the five flush records
//   and the chunk length record.
// A stalled receiver holds the result register and stops the back; the queue then
// fills and req_ready drops. Reset clears all run state, the chunk counters,
// the queue and the result valid flag, and restores the register defaults.
module pad_input_run_length_recorder import prlr_pkg::*; #(
    parameter int MAX_CHUNKS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [1:0]        kind,
    input  logic              connected,
    input  logic              in_stage,
    input  logic [31:0]       quarter_frame,
    input  logic [31:0]       buttons_down,
    input  logic [31:0]       buttons_hit,
    input  logic [7:0]        trigger_left,
    input  logic [7:0]        trigger_right,
    input  logic [31:0]       stick_magnitude,
    input  logic signed [15:0] stick_heading,
    input  logic              camera_present,
    input  logic signed [15:0] camera_angle,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [2:0]        status,
    output logic [2:0]        channel,
    output logic [31:0]       start_frame,
    output logic [31:0]       duration,
    output logic [31:0]       run_value,
    output logic [3:0]        chunk_index,
    output logic              frames_missed,
    output logic              last
);

    logic                    q_push;
    logic                    q_full;
    logic                    q_pop;
    logic                    q_empty;
    cmd_t                    push_cmd;
    logic [$bits(cmd_t)-1:0] pop_bits;

    prlr_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .kind            (kind),
        .connected       (connected),
        .in_stage        (in_stage),
        .quarter_frame   (quarter_frame),
        .buttons_down    (buttons_down),
        .buttons_hit     (buttons_hit),
        .trigger_left    (trigger_left),
        .trigger_right   (trigger_right),
        .stick_magnitude (stick_magnitude),
        .stick_heading   (stick_heading),
        .camera_present  (camera_present),
        .camera_angle    (camera_angle),
        .q_push          (q_push),
        .q_cmd           (push_cmd),
        .q_full          (q_full)
    );

    prlr_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_bits),
        .empty     (q_empty)
    );

    prlr_back #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_cmd         (cmd_t'(pop_bits)),
        .q_pop         (q_pop),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .status        (status),
        .channel       (channel),
        .start_frame   (start_frame),
        .duration      (duration),
        .run_value     (run_value),
        .chunk_index   (chunk_index),
        .frames_missed (frames_missed),
        .last          (last)
    );

endmodule

// ===== sv/prlr_fifo.sv =====
// Small request queue between the front and back parts
module prlr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/prlr_front.sv =====
// Front part: register port, request classification and frame tracking
module prlr_front import prlr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [1:0]        kind,
    input  logic              connected,
    input  logic              in_stage,
    input  logic [31:0]       quarter_frame,
    input  logic [31:0]       buttons_down,
    input  logic [31:0]       buttons_hit,
    input  logic [7:0]        trigger_left,
    input  logic [7:0]        trigger_right,
    input  logic [31:0]       stick_magnitude,
    input  logic signed [15:0] stick_heading,
    input  logic              camera_present,
    input  logic signed [15:0] camera_angle,
    output logic              q_push,
    output cmd_t              q_cmd,
    input  logic              q_full
);

    logic        camera_mode_reg, camera_mode_next;
    logic [31:0] link_mask_reg, link_mask_next;
    logic        recording_reg, recording_next;
    logic [31:0] last_frame_reg, last_frame_next;

    logic        accept;
    logic        cfg_wr;
    logic [31:0] step;
    logic [15:0] dir;

    assign pready    = 1'b1;
    assign req_ready = !q_full;
    assign accept    = req_valid && req_ready;
    assign cfg_wr    = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_LINK_MASK) ? link_mask_reg
                                                   : {31'd0, camera_mode_reg};

    assign step = in_stage ? (quarter_frame - last_frame_reg) : 32'd1;
    assign dir  = (camera_mode_reg && camera_present) ? (stick_heading + camera_angle)
                                                      : stick_heading;

    always_comb
    begin
        camera_mode_next = camera_mode_reg;
        link_mask_next   = link_mask_reg;
        recording_next   = recording_reg;
        last_frame_next  = last_frame_reg;
        q_push           = 1'b0;

        q_cmd            = '0;
        q_cmd.op         = OP_SAMPLE;
        q_cmd.vals[0]    = buttons_down & ~link_mask_reg;
        q_cmd.vals[1]    = {24'd0, trigger_left};
        q_cmd.vals[2]    = {24'd0, trigger_right};
        q_cmd.vals[3]    = stick_magnitude;
        q_cmd.vals[4]    = {16'd0, dir};
        q_cmd.pressed_nz = (buttons_hit & ~link_mask_reg) != 32'd0;
        q_cmd.link       = (buttons_hit & link_mask_reg) != 32'd0;
        q_cmd.missed     = in_stage && (step > 32'd1);
        q_cmd.a          = step;
        q_cmd.b          = last_frame_reg + step;

        if (cfg_wr)
        begin
            if (paddr[2] == REG_LINK_MASK)
            begin
                link_mask_next = pwdata;
            end
            else
            begin
                camera_mode_next = pwdata[0];
            end
        end

        if (accept)
        begin
            case (kind)
                KIND_START:
                begin
                    if (!in_stage && camera_mode_reg)
                    begin
                        q_push   = 1'b1;
                        q_cmd.op = OP_REFUSE;
                    end
                    else
                    begin
                        q_push          = 1'b1;
                        q_cmd.op        = OP_START;
                        q_cmd.b         = in_stage ? quarter_frame : 32'd0;
                        last_frame_next = q_cmd.b;
                        recording_next  = 1'b1;
                    end
                end
                KIND_STOP:
                begin
                    q_push         = 1'b1;
                    q_cmd.op       = OP_STOP;
                    q_cmd.b        = last_frame_reg;
                    recording_next = 1'b0;
                end
                KIND_SAMPLE:
                begin
                    if (recording_reg)
                    begin
                        if (!connected)
                        begin
                            q_push   = 1'b1;
                            q_cmd.op = OP_DISC;
                        end
                        else if (in_stage && step[31])
                        begin
                            q_push         = 1'b1;
                            q_cmd.op       = OP_ORDER;
                            q_cmd.a        = quarter_frame;
                            q_cmd.b        = last_frame_reg;
                            recording_next = 1'b0;
                        end
                        else if (step != 32'd0)
                        begin
                            q_push          = 1'b1;
                            last_frame_next = q_cmd.b;
                        end
                    end
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_mode_reg <= 1'b0;
            link_mask_reg   <= LINK_MASK_RESET;
            recording_reg   <= 1'b0;
            last_frame_reg  <= 32'd0;
        end
        else
        begin
            camera_mode_reg <= camera_mode_next;
            link_mask_reg   <= link_mask_next;
            recording_reg   <= recording_next;
            last_frame_reg  <= last_frame_next;
        end
    end

endmodule

// ===== sv/prlr_back.sv =====
// Back part: per-channel run state, chunk bookkeeping and result output register
`include "pad_input_run_length_recorder_macros.svh"

module prlr_back import prlr_pkg::*; #(
    parameter int MAX_CHUNKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [2:0]  status,
    output logic [2:0]  channel,
    output logic [31:0] start_frame,
    output logic [31:0] duration,
    output logic [31:0] run_value,
    output logic [3:0]  chunk_index,
    output logic        frames_missed,
    output logic        last
);

    localparam int CW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

    typedef enum logic [3:0] {
        BS_IDLE  = 4'b0001,
        BS_SCAN  = 4'b0010,
        BS_FLUSH = 4'b0100,
        BS_CHUNK = 4'b1000
    } bstate_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  channel;
        logic [31:0] start_frame;
        logic [31:0] duration;
        logic [31:0] run_value;
        logic [3:0]  chunk_index;
        logic        missed;
        logic        last;
    } res_t;

    bstate_t                 state_reg, state_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [NUM_CH-1:0]       mask_reg, mask_next;
    logic [2:0]              ch_reg, ch_next;
    logic [NUM_CH-1:0][31:0] run_start_reg, run_start_next;
    logic [NUM_CH-1:0][31:0] run_frames_reg, run_frames_next;
    logic [NUM_CH-1:0][31:0] run_held_reg, run_held_next;
    logic [31:0]             chunk_start_reg, chunk_start_next;
    logic [CW-1:0]           chunk_num_reg, chunk_num_next;
    logic                    res_valid_reg, res_valid_next;
    res_t                    res_reg, res_next;

    logic              slot_free;
    logic              emit;
    logic [31:0]       frames;
    logic [31:0]       chunk_ext;
    logic [CW:0]       chunk_inc;
    logic              no_more;
    logic [NUM_CH-1:0] head_mask;

    assign slot_free = !res_valid_reg || res_ready;
    assign frames    = run_frames_reg[ch_reg] + cmd_reg.a;
    assign chunk_ext = 32'(chunk_num_reg);
    assign chunk_inc = {1'b0, chunk_num_reg} + (CW + 1)'(1);

    always_comb
    begin
        no_more = 1'b1;
        for (int i = 0; i < NUM_CH; i++)
        begin
            if ((3'(i) > ch_reg) && mask_reg[i])
            begin
                no_more = 1'b0;
            end
        end
        for (int i = 0; i < NUM_CH; i++)
        begin
            head_mask[i] = q_cmd.vals[i] != run_held_reg[i];
        end
        head_mask[0] = head_mask[0] || q_cmd.pressed_nz;
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        mask_next        = mask_reg;
        ch_next          = ch_reg;
        run_start_next   = run_start_reg;
        run_frames_next  = run_frames_reg;
        run_held_next    = run_held_reg;
        chunk_start_next = chunk_start_reg;
        chunk_num_next   = chunk_num_reg;
        q_pop            = 1'b0;
        emit             = 1'b0;

        res_next             = '0;
        res_next.status      = ST_RUN;
        res_next.chunk_index = chunk_ext[3:0];

        case (state_reg)
            BS_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_cmd.op)
                        OP_START:
                        begin
                            q_pop            = 1'b1;
                            chunk_num_next   = '0;
                            chunk_start_next = q_cmd.b;
                            run_start_next   = '0;
                            run_frames_next  = '0;
                            run_held_next    = '0;
                        end
                        OP_STOP:
                        begin
                            q_pop            = 1'b1;
                            chunk_start_next = q_cmd.b;
                            run_start_next   = '0;
                            run_frames_next  = '0;
                            run_held_next    = '0;
                        end
                        OP_REFUSE, OP_DISC:
                        begin
                            if (slot_free)
                            begin
                                q_pop           = 1'b1;
                                emit            = 1'b1;
                                res_next.status = (q_cmd.op == OP_REFUSE) ? ST_REFUSED
                                                                          : ST_DISCONN;
                                res_next.last   = 1'b1;
                            end
                        end
                        OP_ORDER:
                        begin
                            if (slot_free)
                            begin
                                q_pop                = 1'b1;
                                emit                 = 1'b1;
                                res_next.status      = ST_ORDER;
                                res_next.start_frame = q_cmd.a;
                                res_next.last        = 1'b1;
                                chunk_start_next     = q_cmd.b;
                                run_start_next       = '0;
                                run_frames_next      = '0;
                                run_held_next        = '0;
                            end
                        end
                        OP_SAMPLE:
                        begin
                            q_pop      = 1'b1;
                            cmd_next   = q_cmd;
                            mask_next  = head_mask;
                            ch_next    = CH_BUTTONS;
                            state_next = BS_SCAN;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            BS_SCAN:
            begin
                if (!mask_reg[ch_reg] || slot_free)
                begin
                    if (mask_reg[ch_reg])
                    begin
                        emit                    = 1'b1;
                        res_next.channel        = ch_reg;
                        res_next.start_frame    = run_start_reg[ch_reg];
                        res_next.duration       = frames;
                        res_next.run_value      = run_held_reg[ch_reg];
                        res_next.missed         = cmd_reg.missed;
                        res_next.last           = !cmd_reg.link && no_more;
                        run_start_next[ch_reg]  = cmd_reg.b;
                        run_frames_next[ch_reg] = 32'd0;
                        run_held_next[ch_reg]   = cmd_reg.vals[ch_reg];
                    end
                    else
                    begin
                        run_frames_next[ch_reg] = frames;
                    end
                    if (ch_reg == CH_LAST)
                    begin
                        ch_next    = CH_BUTTONS;
                        state_next = cmd_reg.link ? BS_FLUSH : BS_IDLE;
                    end
                    else
                    begin
                        ch_next = ch_reg + 3'd1;
                    end
                end
            end
            BS_FLUSH:
            begin
                if (slot_free)
                begin
                    emit                 = 1'b1;
                    res_next.channel     = ch_reg;
                    res_next.start_frame = run_start_reg[ch_reg];
                    res_next.duration    = run_frames_reg[ch_reg];
                    res_next.run_value   = run_held_reg[ch_reg];
                    res_next.missed      = cmd_reg.missed;
                    if (ch_reg == CH_LAST)
                    begin
                        ch_next    = CH_BUTTONS;
                        state_next = BS_CHUNK;
                    end
                    else
                    begin
                        ch_next = ch_reg + 3'd1;
                    end
                end
            end
            BS_CHUNK:
            begin
                if (slot_free)
                begin
                    emit                 = 1'b1;
                    res_next.status      = ST_CHUNK;
                    res_next.start_frame = chunk_start_reg;
                    res_next.duration    = cmd_reg.b - chunk_start_reg;
                    res_next.missed      = cmd_reg.missed;
                    res_next.last        = 1'b1;
                    if (chunk_inc < (CW + 1)'(MAX_CHUNKS))
                    begin
                        chunk_num_next = chunk_inc[CW-1:0];
                    end
                    chunk_start_next = cmd_reg.b;
                    run_start_next   = '0;
                    run_frames_next  = '0;
                    run_held_next    = '0;
                    state_next       = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase

        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_valid_next = res_valid_reg && !res_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BS_IDLE;
            mask_reg        <= '0;
            ch_reg          <= CH_BUTTONS;
            run_start_reg   <= '0;
            run_frames_reg  <= '0;
            run_held_reg    <= '0;
            chunk_start_reg <= 32'd0;
            chunk_num_reg   <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mask_reg        <= mask_next;
            ch_reg          <= ch_next;
            run_start_reg   <= run_start_next;
            run_frames_reg  <= run_frames_next;
            run_held_reg    <= run_held_next;
            chunk_start_reg <= chunk_start_next;
            chunk_num_reg   <= chunk_num_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign status        = res_reg.status;
    assign channel       = res_reg.channel;
    assign start_frame   = res_reg.start_frame;
    assign duration      = res_reg.duration;
    assign run_value     = res_reg.run_value;
    assign chunk_index   = res_reg.chunk_index;
    assign frames_missed = res_reg.missed;
    assign last          = res_reg.last;

    `PRLR_ASSERT_IMP(a_flush_needs_link, (state_reg == BS_FLUSH) || (state_reg == BS_CHUNK), cmd_reg.link)
    `PRLR_ASSERT_IMP(a_channel_range, state_reg != BS_IDLE, ch_reg <= CH_LAST)
    `PRLR_ASSERT_IMP(a_single_is_last, res_valid_reg && (res_reg.status != ST_RUN), res_reg.last)
    `PRLR_ASSERT_NXT(a_chunk_ends_item, emit && (state_reg == BS_CHUNK), state_reg == BS_IDLE)

endmodule

// ===== tb/pad_input_run_length_recorder_test.sv =====
// Self-checking testbench of the pad input run-length recorder with a scoreboard predictor
module pad_input_run_length_recorder_test import prlr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CHUNKS = 16;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic        connected;
        logic        in_stage;
        logic [31:0] quarter_frame;
        logic [31:0] buttons_down;
        logic [31:0] buttons_hit;
        logic [7:0]  trigger_left;
        logic [7:0]  trigger_right;
        logic [31:0] stick_magnitude;
        logic [15:0] stick_heading;
        logic        camera_present;
        logic [15:0] camera_angle;
    } pad_request_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  channel;
        logic [31:0] start_frame;
        logic [31:0] duration;
        logic [31:0] run_value;
        logic [3:0]  chunk_index;
        logic        frames_missed;
        logic        last;
    } run_record_t;

    class recorder_scoreboard;
        logic        cam_mode;
        logic [31:0] link_mask;
        logic        recording;
        logic [31:0] last_frame;
        logic [31:0] chunk_start;
        int          chunk_num;
        logic [31:0] run_start [NUM_CH];
        logic [31:0] run_frames [NUM_CH];
        logic [31:0] run_held [NUM_CH];
        run_record_t due_records [$];
        int          errors;
        int          shown;

        function new();
            cam_mode = 1'b0;
            link_mask = LINK_MASK_RESET;
            recording = 1'b0;
            last_frame = '0;
            chunk_num = 0;
            errors = 0;
            shown = 0;
            clear_runs();
        endfunction

        function void clear_runs();
            chunk_start = last_frame;
            for (int c = 0; c < NUM_CH; c++)
            begin
                run_start[c] = '0;
                run_frames[c] = '0;
                run_held[c] = '0;
            end
        endfunction

        function void set_register(logic reg_idx, logic [31:0] value);
            if (reg_idx == REG_CAMERA_MODE)
                cam_mode = value[0];
            else
                link_mask = value;
        endfunction

        function void push_record(status_t st, logic [2:0] ch, logic [31:0] first_frame,
                                  logic [31:0] dur, logic [31:0] value, logic missed);
            run_record_t r;
            r.status = st;
            r.channel = ch;
            r.start_frame = first_frame;
            r.duration = dur;
            r.run_value = value;
            r.chunk_index = 4'(chunk_num);
            r.frames_missed = missed;
            r.last = 1'b0;
            due_records = {due_records, r};
        endfunction

        function void mark_last(int first);
            run_record_t r;
            int          idx;
            if (due_records.size() > first)
            begin
                idx = due_records.size() - 1;
                r = due_records[idx];
                r.last = 1'b1;
                due_records[idx] = r;
            end
        endfunction

        // works out the records one accepted request causes
        function void note_request(pad_request_t q);
            logic [31:0] vals [NUM_CH];
            logic [31:0] held;
            logic [31:0] pressed;
            logic [31:0] step;
            logic [31:0] now_frame;
            logic [15:0] dir;
            logic        link;
            logic        missed;
            logic        changed;
            int          first;
            first = due_records.size();
            if (q.kind == KIND_START)
            begin
                if (q.in_stage)
                    last_frame = q.quarter_frame;
                else if (cam_mode)
                begin
                    push_record(ST_REFUSED, CH_BUTTONS, '0, '0, '0, 1'b0);
                    mark_last(first);
                    return;
                end
                else
                    last_frame = '0;
                chunk_num = 0;
                clear_runs();
                recording = 1'b1;
                return;
            end
            if (q.kind == KIND_STOP)
            begin
                recording = 1'b0;
                clear_runs();
                return;
            end
            if (q.kind != KIND_SAMPLE || !recording)
                return;
            if (!q.connected)
            begin
                push_record(ST_DISCONN, CH_BUTTONS, '0, '0, '0, 1'b0);
                mark_last(first);
                return;
            end
            link = (q.buttons_hit & link_mask) != '0;
            held = q.buttons_down & ~link_mask;
            pressed = q.buttons_hit & ~link_mask;
            dir = q.stick_heading;
            if (cam_mode && q.camera_present)
                dir = q.stick_heading + q.camera_angle;
            vals[0] = held;
            vals[1] = {24'h0, q.trigger_left};
            vals[2] = {24'h0, q.trigger_right};
            vals[3] = q.stick_magnitude;
            vals[4] = {16'h0, dir};
            step = 32'd1;
            missed = 1'b0;
            if (q.in_stage)
            begin
                step = q.quarter_frame - last_frame;
                if (step == '0)
                    return;
                if (step[31])
                begin
                    push_record(ST_ORDER, CH_BUTTONS, q.quarter_frame, '0, '0, 1'b0);
                    recording = 1'b0;
                    clear_runs();
                    mark_last(first);
                    return;
                end
                missed = step > 32'd1;
            end
            now_frame = last_frame + step;
            for (int c = 0; c < NUM_CH; c++)
            begin
                run_frames[c] += step;
                changed = vals[c] != run_held[c];
                if (c == 0 && pressed != '0)
                    changed = 1'b1;
                if (changed)
                begin
                    push_record(ST_RUN, 3'(c), run_start[c], run_frames[c], run_held[c], missed);
                    run_start[c] = now_frame;
                    run_frames[c] = '0;
                    run_held[c] = vals[c];
                end
            end
            last_frame = now_frame;
            if (link)
            begin
                for (int c = 0; c < NUM_CH; c++)
                    push_record(ST_RUN, 3'(c), run_start[c], run_frames[c], run_held[c], missed);
                push_record(ST_CHUNK, CH_BUTTONS, chunk_start, last_frame - chunk_start, '0,
                            missed);
                if (chunk_num + 1 < MAX_CHUNKS)
                    chunk_num++;
                clear_runs();
            end
            mark_last(first);
        endfunction

        function void check_record(run_record_t got);
            run_record_t want;
            if (due_records.size() == 0)
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("unexpected record: st %0d ch %0d start %h dur %h val %h last %b",
                             got.status, got.channel, got.start_frame, got.duration,
                             got.run_value, got.last);
                end
                return;
            end
            want = due_records.pop_front();
            if (got !== want)
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("record mismatch at %0t", $realtime);
                    $display("  exp st %0d ch %0d start %h dur %h val %h chunk %0d miss %b last %b",
                             want.status, want.channel, want.start_frame, want.duration,
                             want.run_value, want.chunk_index, want.frames_missed, want.last);
                    $display("  got st %0d ch %0d start %h dur %h val %h chunk %0d miss %b last %b",
                             got.status, got.channel, got.start_frame, got.duration,
                             got.run_value, got.chunk_index, got.frames_missed, got.last);
                end
            end
        endfunction

        function void drain();
            if (due_records.size() != 0)
            begin
                $display("%0d records never arrived", due_records.size());
                errors += due_records.size();
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              req_valid;
    logic              req_ready;
    logic [1:0]        kind;
    logic              connected;
    logic              in_stage;
    logic [31:0]       quarter_frame;
    logic [31:0]       buttons_down;
    logic [31:0]       buttons_hit;
    logic [7:0]        trigger_left;
    logic [7:0]        trigger_right;
    logic [31:0]       stick_magnitude;
    logic [15:0]       stick_heading;
    logic              camera_present;
    logic [15:0]       camera_angle;
    logic              res_valid;
    logic              res_ready;
    logic [2:0]        status;
    logic [2:0]        channel;
    logic [31:0]       start_frame;
    logic [31:0]       duration;
    logic [31:0]       run_value;
    logic [3:0]        chunk_index;
    logic              frames_missed;
    logic              last;

    recorder_scoreboard sb;
    pad_request_t       pad;
    int unsigned        burst_left;

    pad_input_run_length_recorder #(.MAX_CHUNKS(MAX_CHUNKS)) dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req_valid(req_valid), .req_ready(req_ready),
        .kind(kind), .connected(connected), .in_stage(in_stage),
        .quarter_frame(quarter_frame), .buttons_down(buttons_down),
        .buttons_hit(buttons_hit), .trigger_left(trigger_left),
        .trigger_right(trigger_right), .stick_magnitude(stick_magnitude),
        .stick_heading(stick_heading), .camera_present(camera_present),
        .camera_angle(camera_angle),
        .res_valid(res_valid), .res_ready(res_ready),
        .status(status), .channel(channel), .start_frame(start_frame),
        .duration(duration), .run_value(run_value), .chunk_index(chunk_index),
        .frames_missed(frames_missed), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver stall pattern: random spans of always ready, coin flips and long stalls
    initial
    begin : receiver
        int unsigned mode;
        int unsigned span;
        int unsigned stall;
        res_ready = 1'b0;
        stall = 0;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(40, 160);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: res_ready = 1'b1;
                    1: res_ready = 1'($urandom_range(0, 1));
                    default:
                    begin
                        if (stall > 0)
                        begin
                            res_ready = 1'b0;
                            stall--;
                        end
                        else
                        begin
                            res_ready = 1'b1;
                            if ($urandom_range(0, 5) == 0)
                                stall = $urandom_range(1, 8);
                        end
                    end
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        run_record_t got;
        if (rst_n && res_valid && res_ready)
        begin
            got.status = status_t'(status);
            got.channel = channel;
            got.start_frame = start_frame;
            got.duration = duration;
            got.run_value = run_value;
            got.chunk_index = chunk_index;
            got.frames_missed = frames_missed;
            got.last = last;
            sb.check_record(got);
        end
    end

    function automatic pad_request_t blank(input logic [1:0] k);
        pad_request_t q;
        q.kind = k;
        q.connected = 1'b1;
        q.in_stage = 1'b0;
        q.quarter_frame = '0;
        q.buttons_down = '0;
        q.buttons_hit = '0;
        q.trigger_left = '0;
        q.trigger_right = '0;
        q.stick_magnitude = '0;
        q.stick_heading = '0;
        q.camera_present = 1'b0;
        q.camera_angle = '0;
        return q;
    endfunction

    function automatic pad_request_t noise_req();
        pad_request_t q;
        case ($urandom_range(0, 2))
            0: q.kind = KIND_UNKNOWN;
            1: q.kind = KIND_SAMPLE;
            default: q.kind = KIND_STOP;
        endcase
        q.connected = 1'($urandom_range(0, 1));
        q.in_stage = 1'($urandom_range(0, 1));
        q.quarter_frame = $urandom();
        q.buttons_down = $urandom();
        q.buttons_hit = $urandom();
        q.trigger_left = 8'($urandom());
        q.trigger_right = 8'($urandom());
        q.stick_magnitude = $urandom();
        q.stick_heading = 16'($urandom());
        q.camera_present = 1'($urandom_range(0, 1));
        q.camera_angle = 16'($urandom());
        return q;
    endfunction

    // pad levels drift slowly so that runs last several frames
    function automatic void stir_pad();
        if ($urandom_range(0, 6) == 0)
            pad.buttons_down = $urandom() & $urandom();
        if ($urandom_range(0, 6) == 0)
            pad.trigger_left = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom());
        if ($urandom_range(0, 6) == 0)
            pad.trigger_right = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom());
        if ($urandom_range(0, 9) == 0)
            pad.stick_magnitude = $urandom();
        if ($urandom_range(0, 4) == 0)
            pad.stick_heading = 16'($urandom());
        if ($urandom_range(0, 4) == 0)
            pad.camera_angle = 16'($urandom());
        if ($urandom_range(0, 9) == 0)
            pad.camera_present = ~pad.camera_present;
    endfunction

    task automatic send(input pad_request_t q);
        @(negedge clk);
        if (burst_left == 0)
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
        end
        kind = q.kind;
        connected = q.connected;
        in_stage = q.in_stage;
        quarter_frame = q.quarter_frame;
        buttons_down = q.buttons_down;
        buttons_hit = q.buttons_hit;
        trigger_left = q.trigger_left;
        trigger_right = q.trigger_right;
        stick_magnitude = q.stick_magnitude;
        stick_heading = q.stick_heading;
        camera_present = q.camera_present;
        camera_angle = q.camera_angle;
        req_valid = 1'b1;
        do @(posedge clk); while (!req_ready);
        sb.note_request(q);
        burst_left--;
    endtask

    // drop valid, let every expected record arrive, then cover the back end latency
    task automatic settle();
        @(negedge clk);
        req_valid = 1'b0;
        while (sb.due_records.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {reg_idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_register(reg_idx, value);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // start, a run of samples with mostly rising frame counts, then usually stop
    task automatic run_session(inout int unsigned n, input int unsigned len,
                               input int unsigned link_pct);
        pad_request_t q;
        logic         stage;
        logic [31:0]  frame;
        logic [31:0]  delta;
        logic [31:0]  lowbit;
        int unsigned  r;
        stage = sb.cam_mode ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 3))
            0: frame = '0;
            1: frame = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
            default: frame = $urandom();
        endcase
        q = pad;
        q.kind = KIND_START;
        q.in_stage = stage;
        q.quarter_frame = frame;
        send(q);
        n++;
        if (!stage)
            frame = '0;
        repeat (len)
        begin
            stir_pad();
            q = pad;
            q.kind = KIND_SAMPLE;
            q.connected = ($urandom_range(0, 24) != 0);
            q.in_stage = stage ^ ($urandom_range(0, 19) == 0);
            lowbit = sb.link_mask & (~sb.link_mask + 32'd1);
            if ($urandom_range(0, 99) < link_pct)
                q.buttons_hit = lowbit | ($urandom() & $urandom());
            else if ($urandom_range(0, 9) == 0)
                q.buttons_hit = $urandom() & ~sb.link_mask;
            else
                q.buttons_hit = '0;
            r = $urandom_range(0, 99);
            if (r < 60)
                delta = 32'd1;
            else if (r < 82)
                delta = $urandom_range(2, 6);
            else if (r < 92)
                delta = '0;
            else if (r < 97)
                delta = $urandom_range(7, 1000000);
            else
                delta = -32'($urandom_range(1, 9));
            q.quarter_frame = q.in_stage ? frame + delta : $urandom();
            send(q);
            n++;
            if (q.connected)
            begin
                if (!q.in_stage)
                    frame += 32'd1;
                else if (delta[31])
                    return;
                else
                    frame += delta;
            end
        end
        if ($urandom_range(0, 4) != 0)
        begin
            send(blank(KIND_STOP));
            n++;
        end
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned n;
        int unsigned pct;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                send(noise_req());
                n++;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: pct = 0;
                    1: pct = 10;
                    2: pct = 35;
                    default: pct = 90;
                endcase
                run_session(n, $urandom_range(3, 24), pct);
            end
        end
    endtask

    initial
    begin
        pad_request_t q;
        int unsigned  n;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_valid = 1'b0;
        kind = KIND_START;
        connected = 1'b0;
        in_stage = 1'b0;
        quarter_frame = '0;
        buttons_down = '0;
        buttons_hit = '0;
        trigger_left = '0;
        trigger_right = '0;
        stick_magnitude = '0;
        stick_heading = '0;
        camera_present = 1'b0;
        camera_angle = '0;
        burst_left = 4;
        sb = new();
        pad = blank(KIND_SAMPLE);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed requests with the reset register values
        q = blank(KIND_SAMPLE);
        send(q);
        q.kind = KIND_UNKNOWN;
        send(q);
        send(blank(KIND_STOP));
        send(blank(KIND_START));
        send(blank(KIND_SAMPLE));
        q = blank(KIND_SAMPLE);
        q.quarter_frame = '1;
        q.buttons_down = '1;
        q.trigger_left = '1;
        q.trigger_right = '1;
        q.stick_magnitude = '1;
        q.stick_heading = 16'h8000;
        q.camera_present = 1'b1;
        q.camera_angle = 16'h7FFF;
        send(q);
        q.connected = 1'b0;
        send(q);
        q.connected = 1'b1;
        q.buttons_hit = 32'h0000_0001;
        send(q);
        q.buttons_hit = LINK_MASK_RESET;
        send(q);
        q = blank(KIND_START);
        q.in_stage = 1'b1;
        q.quarter_frame = 32'd100;
        send(q);
        q.kind = KIND_SAMPLE;
        send(q);
        q.quarter_frame = 32'd101;
        q.stick_heading = 16'h7FFF;
        send(q);
        q.quarter_frame = 32'd105;
        q.trigger_left = 8'h80;
        send(q);
        q.quarter_frame = 32'd50;
        send(q);
        q = blank(KIND_START);
        q.in_stage = 1'b1;
        q.quarter_frame = 32'hFFFF_FFF0;
        send(q);
        q.kind = KIND_SAMPLE;
        q.quarter_frame = '1;
        q.buttons_down = 32'h0000_0005;
        send(q);
        q.quarter_frame = 32'd5;
        q.trigger_right = 8'h01;
        send(q);
        q.quarter_frame = 32'd6;
        q.buttons_hit = '1;
        send(q);
        send(blank(KIND_STOP));

        settle();
        write_reg(REG_CAMERA_MODE, 32'd1);
        send(blank(KIND_START));
        q = blank(KIND_START);
        q.in_stage = 1'b1;
        q.quarter_frame = 32'd1000;
        send(q);
        q.kind = KIND_SAMPLE;
        q.quarter_frame = 32'd1001;
        q.stick_heading = 16'h7FFF;
        q.camera_present = 1'b1;
        q.camera_angle = 16'h0001;
        send(q);
        q.quarter_frame = 32'd1002;
        q.camera_present = 1'b0;
        send(q);
        send(blank(KIND_STOP));

        // random phases over several register settings
        settle();
        write_reg(REG_LINK_MASK, '1);
        n = 0;
        run_session(n, 20, 100);
        random_phase(24);

        settle();
        write_reg(REG_CAMERA_MODE, 32'd0);
        write_reg(REG_LINK_MASK, '0);
        random_phase(28);

        settle();
        write_reg(REG_CAMERA_MODE, 32'd1);
        write_reg(REG_LINK_MASK, $urandom() | 32'h0000_0100);
        random_phase(28);

        settle();
        write_reg(REG_CAMERA_MODE, 32'd0);
        write_reg(REG_LINK_MASK, LINK_MASK_RESET);
        random_phase(28);

        settle();
        write_reg(REG_CAMERA_MODE, 32'd1);
        write_reg(REG_LINK_MASK, 32'h1 << $urandom_range(0, 31));
        random_phase(28);

        settle();
        sb.drain();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== pad_input_run_length_recorder.f =====
+incdir+sv
sv/prlr_pkg.sv
sv/prlr_fifo.sv
sv/prlr_front.sv
sv/prlr_back.sv
sv/pad_input_run_length_recorder.sv
tb/pad_input_run_length_recorder_test.sv
